/* sv/pct_pkg.sv */
`default_nettype none

package pct_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] MinusChar = 8'h2D;

  // Result queue geometry
  localparam int QueueDepth = 8;
  localparam int QueueAw    = $clog2(QueueDepth);
  // Highest fill level that still leaves room for two in-flight items
  localparam int QueueLimit = QueueDepth - 4;

  // Held-byte count codes
  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldPct   = 2'd1;
  localparam logic [1:0] HeldDigit = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // Results of one item handed to the queue
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == SpaceChar) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Two-character base-16 conversion with leading space and sign rules
  function automatic logic [7:0] convert_pair(input logic [7:0] a, input logic [7:0] b);
    hex_t       ha;
    hex_t       hb;
    logic [7:0] r;
    ha = hex_val(a);
    hb = hex_val(b);
    r  = 8'd0;
    if (ha.ok) begin
      r = hb.ok ? {ha.val, hb.val} : {4'd0, ha.val};
    end else if (hb.ok) begin
      if (is_ws(a) || a == PlusChar) begin
        r = {4'd0, hb.val};
      end else if (a == MinusChar) begin
        r = 8'(8'd0 - {4'd0, hb.val});
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == PlusChar) ? SpaceChar : c;
  endfunction

endpackage

`default_nettype wire

/* sv/pct_decode.sv */
`default_nettype none

module pct_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire pct_pkg::in_t  item,
  output pct_pkg::push_t     push,
  output logic               busy
);
  import pct_pkg::*;

  logic       stage_valid;
  in_t        stage;
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= take;
    end
    if (take) begin
      stage <= item;
    end
  end

  // Decode the staged item against the held bytes
  always_comb begin
    held_count_next = held_count;
    held_digit_next = held_digit;
    push.count      = 2'd0;
    push.first      = '{out_byte: plain_map(stage.in_byte), out_last: stage.in_last};
    push.second     = '{out_byte: plain_map(stage.in_byte), out_last: 1'b1};
    if (stage_valid) begin
      case (held_count)
        HeldPct: begin
          if (!stage.in_last) begin
            held_digit_next = stage.in_byte;
            held_count_next = HeldDigit;
          end else begin
            held_count_next = HeldNone;
            push.count      = 2'd2;
            push.first      = '{out_byte: PctChar, out_last: 1'b0};
          end
        end
        HeldDigit: begin
          held_count_next = HeldNone;
          push.count      = 2'd1;
          push.first.out_byte = convert_pair(held_digit, stage.in_byte);
        end
        default: begin
          if (stage.in_byte == PctChar && !stage.in_last) begin
            held_count_next = HeldPct;
          end else begin
            held_count_next = HeldNone;
            push.count      = 2'd1;
          end
        end
      endcase
    end
  end

  // Advance the held state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HeldNone;
      held_digit <= 8'd0;
    end else begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

  assign busy = stage_valid;

endmodule

`default_nettype wire

/* sv/pct_queue.sv */
`default_nettype none

module pct_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pct_pkg::push_t  push,
  input  wire logic            pop,
  output pct_pkg::out_t        head,
  output logic                 head_valid,
  output logic [pct_pkg::QueueAw:0] level
);
  import pct_pkg::*;

  out_t             mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   count;
  logic [QueueAw:0]   count_next;
  logic [QueueAw-1:0] wr_ptr_plus;

  assign wr_ptr_plus = wr_ptr + QueueAw'(1);

  // Store up to two results per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus] <= push.second;
    end
  end

  always_comb begin
    count_next = count + (QueueAw + 1)'(push.count) - (QueueAw + 1)'(pop);
  end

  // Advance the pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueueAw'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QueueAw'(1);
      end
      count <= count_next;
    end
  end

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign level      = count;

endmodule

`default_nettype wire

/* sv/percent_decoder_core.sv */
`default_nettype none

// URL percent decoder. Takes one encoded byte per item (in_last on the final
// byte of a string) and gives the decoded bytes, one per output item. '+'
// becomes a space, '%' plus two bytes becomes their base-16 value, and a
// string that ends inside an escape gives the '%' literally followed by any
// byte already captured. One item is accepted per cycle while in_stall is
// low. An item is captured in the input register and decoded from there
// straight into the queue, from which its results leave. A '%' and the byte
// after it give no result of their own, and a string that ends one byte
// after a '%' gives two results. Results leave through an eight-entry queue,
// one per cycle while out_stall is low. in_stall rises when the queue fill,
// plus two for an item still in the input register, exceeds four.
module percent_decoder_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pct_pkg::in_t  in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pct_pkg::out_t      out_item
);
  import pct_pkg::*;

  push_t            push;
  logic             busy;
  logic             take;
  logic             pop;
  logic [QueueAw:0] level;
  logic [QueueAw:0] committed;

  // Hold input while the queue cannot absorb the staged and next items
  assign committed = level + (busy ? (QueueAw + 1)'(2) : '0);
  assign in_stall  = (committed > (QueueAw + 1)'(QueueLimit));
  assign take      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  pct_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_item),
    .push (push),
    .busy (busy)
  );

  pct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (out_item),
    .head_valid (out_valid),
    .level      (level)
  );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import pct_pkg::*;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam int CycleLimit    = 200000;
  localparam int ItemsPerPhase = 220;
  localparam int LongHold      = 300;
  localparam int DrainCycles   = 8;

  // Escape tracking: nothing held, '%' seen, '%' plus one byte seen
  typedef enum logic [1:0] {
    SCAN      = 2'd0,
    AFTER_PCT = 2'd1,
    AFTER_HI  = 2'd2
  } esc_state_t;

  // One directed item; n_typed < 0 means the decoder model supplies the results
  typedef struct {
    logic [7:0] b;
    logic       l;
    int         n_typed;
    out_t       e0;
    out_t       e1;
  } row_t;

  localparam out_t NoOut = '0;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;

  esc_state_t esc_state;
  logic [7:0] hi_char;
  out_t       decoded_q[$];
  int         mismatches;
  int         cycle_count;
  int         tx_pct;
  int         rx_pct;
  int         hold_left;

  percent_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Directed strings: extremes, '+', lone '%', truncated escapes, sign and space rules
  row_t steps [25] = '{
    '{8'h01,     1'b0,  1, {8'h01, 1'b0}, NoOut},
    '{8'hFF,     1'b0,  1, {8'hFF, 1'b0}, NoOut},
    '{CharPlus,  1'b1,  1, {CharSpace, 1'b1}, NoOut},
    '{CharPct,   1'b1,  1, {CharPct, 1'b1}, NoOut},
    '{CharPct,   1'b0,  0, NoOut, NoOut},
    '{CharPlus,  1'b1,  2, {CharPct, 1'b0}, {CharSpace, 1'b1}},
    '{CharPct,   1'b0,  0, NoOut, NoOut},
    '{"f",       1'b0,  0, NoOut, NoOut},
    '{"F",       1'b1,  1, {8'hFF, 1'b1}, NoOut},
    '{CharPct,   1'b0,  0, NoOut, NoOut},
    '{CharMinus, 1'b0,  0, NoOut, NoOut},
    '{"1",       1'b0,  1, {8'hFF, 1'b0}, NoOut},
    '{CharPct,   1'b0, -1, NoOut, NoOut},
    '{CharSpace, 1'b0, -1, NoOut, NoOut},
    '{"a",       1'b0, -1, NoOut, NoOut},
    '{CharPct,   1'b0, -1, NoOut, NoOut},
    '{"A",       1'b0, -1, NoOut, NoOut},
    '{"z",       1'b0, -1, NoOut, NoOut},
    '{CharPct,   1'b0,  0, NoOut, NoOut},
    '{"g",       1'b0,  0, NoOut, NoOut},
    '{"x",       1'b1,  1, {8'h00, 1'b1}, NoOut},
    '{CharPct,   1'b0, -1, NoOut, NoOut},
    '{CharPlus,  1'b0, -1, NoOut, NoOut},
    '{"7",       1'b1, -1, NoOut, NoOut},
    '{8'h7F,     1'b1,  1, {8'h7F, 1'b1}, NoOut}
  };

  // Hex digit value, or -1 for any other byte
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Base-16 value of a two-byte escape, allowing a leading blank or sign
  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    int na;
    int nb;
    na = nibble_of(a);
    nb = nibble_of(b);
    if (na >= 0) return (nb >= 0) ? 8'(na * 16 + nb) : 8'(na);
    if (nb < 0) return 8'h00;
    if (a == CharPlus || a == CharSpace || (a >= CharTab && a <= CharCr)) return 8'(nb);
    if (a == CharMinus) return 8'(-nb);
    return 8'h00;
  endfunction

  function automatic logic [7:0] unplus(input logic [7:0] c);
    return (c == CharPlus) ? CharSpace : c;
  endfunction

  // Advance the escape state by one byte; return the decoded bytes it yields
  function automatic int decode_byte(input in_t it, output out_t r0, output out_t r1);
    r0 = NoOut;
    r1 = NoOut;
    case (esc_state)
      AFTER_PCT: begin
        if (!it.in_last) begin
          hi_char   = it.in_byte;
          esc_state = AFTER_HI;
          return 0;
        end
        esc_state = SCAN;
        r0 = {CharPct, 1'b0};
        r1 = {unplus(it.in_byte), 1'b1};
        return 2;
      end
      AFTER_HI: begin
        esc_state = SCAN;
        r0 = {pair_value(hi_char, it.in_byte), it.in_last};
        return 1;
      end
      default: begin
        esc_state = SCAN;
        if (it.in_byte == CharPct && !it.in_last) begin
          esc_state = AFTER_PCT;
          return 0;
        end
        r0 = {unplus(it.in_byte), it.in_last};
        return 1;
      end
    endcase
  endfunction

  task automatic queue_decoded(input in_t it);
    out_t r0;
    out_t r1;
    int   n;
    n = decode_byte(it, r0, r1);
    if (n > 0) decoded_q.push_back(r0);
    if (n > 1) decoded_q.push_back(r1);
  endtask

  // Offer one item, idling first at the sender rate; return at its accepting edge
  task automatic offer(input in_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every decoded byte has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random byte weighted toward escapes, hex digits, signs and blanks
  function automatic logic [7:0] pick_char();
    int r;
    int k;
    r = $urandom_range(99);
    k = $urandom_range(21);
    if (r < 25) return CharPct;
    if (r < 45) begin
      if (k < 10) return 8'("0" + k);
      if (k < 16) return 8'("a" + k - 10);
      return 8'("A" + k - 16);
    end
    if (r < 52) return CharPlus;
    if (r < 57) return CharMinus;
    if (r < 63) return (k > 17) ? CharSpace : 8'(CharTab + k % 5);
    return 8'($urandom_range(255, 1));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stall the output at the receiver rate, or hold it off for a counted stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  // Compare each output item with the oldest decoded byte
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("out_item: nothing expected, actual %h/%b", out_item.out_byte, out_item.out_last);
        mismatches++;
      end else begin
        if (out_item.out_byte !== decoded_q[0].out_byte) begin
          $error("out_byte: expected %h, actual %h",
                 decoded_q[0].out_byte, out_item.out_byte);
          mismatches++;
        end
        if (out_item.out_last !== decoded_q[0].out_last) begin
          $error("out_last: expected %b, actual %b",
                 decoded_q[0].out_last, out_item.out_last);
          mismatches++;
        end
        void'(decoded_q.pop_front());
      end
    end
  end

  initial begin
    in_t  it;
    out_t r0;
    out_t r1;
    int   sent;
    int   len;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    mismatches = 0;
    tx_pct     = 0;
    rx_pct     = 0;
    hold_left  = 0;
    esc_state  = SCAN;
    hi_char    = 8'h00;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Walk the directed strings
    foreach (steps[i]) begin
      it = {steps[i].b, steps[i].l};
      offer(it);
      if (steps[i].n_typed < 0) begin
        queue_decoded(it);
      end else begin
        void'(decode_byte(it, r0, r1));
        if (steps[i].n_typed > 0) decoded_q.push_back(steps[i].e0);
        if (steps[i].n_typed > 1) decoded_q.push_back(steps[i].e1);
      end
    end
    drain();

    // Random strings under each idling pattern, then one long output hold-off
    for (int ph = 0; ph < 5; ph++) begin
      tx_pct = (ph == 1) ? 47 : (ph == 3) ? 20 : 0;
      rx_pct = (ph == 2) ? 47 : (ph == 3) ? 20 : 0;
      sent   = 0;
      while (sent < ItemsPerPhase) begin
        len = $urandom_range(10, 1);
        for (int j = 0; j < len; j++) begin
          it = {pick_char(), 1'(j == len - 1)};
          offer(it);
          queue_decoded(it);
          sent++;
          if (ph == 4 && sent == 20) hold_left = LongHold;
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pct_pkg.sv
sv/pct_decode.sv
sv/pct_queue.sv
sv/percent_decoder_core.sv
dv/tb_top.sv
